// ===== rtl/rrqs_pkg.sv =====
`default_nettype none
package rrqs_pkg;

   localparam int SLOTS   = 16;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int CNT_W   = SLOT_W + 1;

   localparam int ID_W    = 16;
   localparam int TIME_W  = 32;
   localparam int Q_W     = 8;
   localparam int PC_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_COUNT = 2'd1;

   localparam logic [Q_W-1:0]    QUANTUM_RESET = 8'd4;
   localparam logic [Q_W-1:0]    SLICE_MAX     = 8'hFF;
   localparam logic [TIME_W-1:0] CLOCK_MAX     = 32'hFFFF_FFFF;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [15:0]     arrival;
      logic [15:0]     remaining;
   } slot_word_type;

   localparam int WORD_W = $bits(slot_word_type);

endpackage
`default_nettype wire

// ===== rtl/rrqs_ram.sv =====
`default_nettype none
module rrqs_ram #(
   parameter int DATA_W = 48,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/round_robin_quantum_scheduler_unit.sv =====
`default_nettype none
// Load word: writes the slot store, then S_FINISH. Tick word: S_KEEP reads the current
// slot while it keeps running, then S_COMMIT, S_FINISH; otherwise, or if it has not
// arrived, S_MOD wraps the start slot to the slots in use; the scan reads pending slots
// and skips idle ones. Slots are scanned one at a time over the store's single read port.
// One word at a time; rsp_strobe is one cycle and cannot be stalled. Synchronous reset
// clears control state, pending bits, clock, process count, quantum to 4; RAM undefined.
module round_robin_quantum_scheduler_unit
   import rrqs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_action,
   input  wire logic [3:0]            req_slot,
   input  wire logic [15:0]           req_process_id,
   input  wire logic [15:0]           req_arrival,
   input  wire logic [15:0]           req_burst_length,
   output logic                       rsp_strobe,
   output logic                       rsp_ran_valid,
   output logic [15:0]                rsp_ran_id,
   output logic                       rsp_finished,
   output logic [31:0]                rsp_time_after,
   output logic                       rsp_all_done,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_KEEP     = 3'd1;
   localparam logic [2:0] S_MOD      = 3'd2;
   localparam logic [2:0] S_SCAN_RD  = 3'd3;
   localparam logic [2:0] S_SCAN_CHK = 3'd4;
   localparam logic [2:0] S_COMMIT   = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [SLOTS-1:0]  pending_ff, pending_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic [Q_W-1:0]    slice_used_ff, slice_used_in;
   logic              active_ff, active_in;
   logic [TIME_W-1:0] clock_now_ff, clock_now_in;
   logic [Q_W-1:0]    quantum_ff;
   logic [PC_W-1:0]   pcount_ff;

   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOT_W-1:0] pick_ff, pick_in;
   logic              found_ff, found_in;
   logic              fresh_ff, fresh_in;

   logic              strobe_ff, strobe_in;
   logic              ran_valid_ff, ran_valid_in;
   logic [ID_W-1:0]   ran_id_ff, ran_id_in;
   logic              finished_ff, finished_in;
   logic [TIME_W-1:0] time_after_ff, time_after_in;
   logic              all_done_ff, all_done_in;

   logic              ram_we, ram_re;
   logic [SLOT_W-1:0] ram_waddr, ram_raddr;
   slot_word_type     ram_wdata, ram_rdata;
   logic [WORD_W-1:0] ram_rdata_raw;

   logic              accept;
   logic              arrived;
   logic              keep_try;
   logic              no_pending;
   logic [CNT_W-1:0]  n_calc;
   logic [Q_W-1:0]    q_calc;
   logic [CNT_W-1:0]  idx_step;
   logic [TIME_W-1:0] clock_step;
   logic [Q_W-1:0]    slice_base;

   rrqs_ram #(
      .DATA_W (WORD_W),
      .ADDR_W (SLOT_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = slot_word_type'(ram_rdata_raw);

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign n_calc = ({27'd0, pcount_ff} > 32'(SLOTS)) ? CNT_W'(SLOTS)
                                                     : CNT_W'({27'd0, pcount_ff});
   assign q_calc = (quantum_ff == '0) ? Q_W'(1) : quantum_ff;

   assign keep_try = active_ff && (slice_used_ff < q_calc) &&
                     ({1'b0, cur_ff} < n_calc) && pending_ff[cur_ff];

   assign arrived    = ({16'd0, ram_rdata.arrival} <= clock_now_ff);
   assign idx_step   = ((idx_ff + CNT_W'(1)) == n_ff) ? '0 : (idx_ff + CNT_W'(1));
   assign clock_step = (clock_now_ff == CLOCK_MAX) ? clock_now_ff
                                                   : (clock_now_ff + TIME_W'(1));
   assign slice_base = fresh_ff ? '0 : slice_used_ff;

   always_comb begin
      no_pending = 1'b1;
      for (int s = 0; s < SLOTS; s++) begin
         if ((CNT_W'(s) < n_calc) && pending_ff[s]) begin
            no_pending = 1'b0;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      pending_in    = pending_ff;
      cur_in        = cur_ff;
      slice_used_in = slice_used_ff;
      active_in     = active_ff;
      clock_now_in  = clock_now_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      pick_in       = pick_ff;
      found_in      = found_ff;
      fresh_in      = fresh_ff;
      strobe_in     = 1'b0;
      ran_valid_in  = ran_valid_ff;
      ran_id_in     = ran_id_ff;
      finished_in   = finished_ff;
      time_after_in = time_after_ff;
      all_done_in   = all_done_ff;
      ram_we        = 1'b0;
      ram_waddr     = pick_ff;
      ram_wdata     = ram_rdata;
      ram_re        = 1'b0;
      ram_raddr     = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action == ACT_LOAD) begin
                  if ({28'd0, req_slot} < 32'(SLOTS)) begin
                     ram_we              = 1'b1;
                     ram_waddr           = SLOT_W'({28'd0, req_slot});
                     ram_wdata.id        = req_process_id;
                     ram_wdata.arrival   = req_arrival;
                     ram_wdata.remaining = req_burst_length;
                     pending_in[SLOT_W'({28'd0, req_slot})] = 1'b1;
                  end
                  ran_valid_in  = 1'b0;
                  ran_id_in     = '0;
                  finished_in   = 1'b0;
                  time_after_in = clock_now_ff;
                  state_in      = S_FINISH;
               end else begin
                  n_in     = n_calc;
                  found_in = 1'b0;
                  fresh_in = 1'b0;
                  if (keep_try) begin
                     ram_re   = 1'b1;
                     ram_raddr = cur_ff;
                     state_in = S_KEEP;
                  end else begin
                     idx_in   = active_ff ? ({1'b0, cur_ff} + CNT_W'(1)) : {1'b0, cur_ff};
                     state_in = (n_calc == '0) ? S_COMMIT : S_MOD;
                  end
               end
            end
         end
         S_KEEP: begin
            if (arrived) begin
               found_in = 1'b1;
               fresh_in = 1'b0;
               pick_in  = cur_ff;
               state_in = S_COMMIT;
            end else begin
               idx_in   = {1'b0, cur_ff} + CNT_W'(1);
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (idx_ff >= n_ff) begin
               idx_in = idx_ff - n_ff;
            end else begin
               cnt_in   = '0;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (pending_ff[idx_ff[SLOT_W-1:0]]) begin
               ram_re    = 1'b1;
               ram_raddr = idx_ff[SLOT_W-1:0];
               state_in  = S_SCAN_CHK;
            end else if ((cnt_ff + CNT_W'(1)) == n_ff) begin
               state_in = S_COMMIT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
               idx_in = idx_step;
            end
         end
         S_SCAN_CHK: begin
            if (arrived) begin
               found_in = 1'b1;
               fresh_in = 1'b1;
               pick_in  = idx_ff[SLOT_W-1:0];
               state_in = S_COMMIT;
            end else if ((cnt_ff + CNT_W'(1)) == n_ff) begin
               state_in = S_COMMIT;
            end else begin
               cnt_in   = cnt_ff + CNT_W'(1);
               idx_in   = idx_step;
               state_in = S_SCAN_RD;
            end
         end
         S_COMMIT: begin
            ran_valid_in = found_ff;
            ran_id_in    = found_ff ? ram_rdata.id : '0;
            finished_in  = 1'b0;
            if (found_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pick_ff;
               slice_used_in = (slice_base == SLICE_MAX) ? slice_base
                                                         : (slice_base + Q_W'(1));
               if (fresh_ff) begin
                  cur_in    = pick_ff;
                  active_in = 1'b1;
               end
               if (ram_rdata.remaining <= 16'd1) begin
                  ram_wdata.remaining = '0;
                  pending_in[pick_ff] = 1'b0;
                  active_in           = 1'b0;
                  finished_in         = 1'b1;
               end else begin
                  ram_wdata.remaining = ram_rdata.remaining - 16'd1;
               end
            end
            clock_now_in  = clock_step;
            time_after_in = clock_step;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            strobe_in   = 1'b1;
            all_done_in = no_pending;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pending_ff    <= '0;
         cur_ff        <= '0;
         slice_used_ff <= '0;
         active_ff     <= 1'b0;
         clock_now_ff  <= '0;
         quantum_ff    <= QUANTUM_RESET;
         pcount_ff     <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pending_ff    <= pending_in;
         cur_ff        <= cur_in;
         slice_used_ff <= slice_used_in;
         active_ff     <= active_in;
         clock_now_ff  <= clock_now_in;
         strobe_ff     <= strobe_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_QUANTUM:       quantum_ff <= csr_data[Q_W-1:0];
               CSR_PROCESS_COUNT: pcount_ff  <= csr_data[PC_W-1:0];
               default:           ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      pick_ff       <= pick_in;
      found_ff      <= found_in;
      fresh_ff      <= fresh_in;
      ran_valid_ff  <= ran_valid_in;
      ran_id_ff     <= ran_id_in;
      finished_ff   <= finished_in;
      time_after_ff <= time_after_in;
      all_done_ff   <= all_done_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_ran_valid  = ran_valid_ff;
   assign rsp_ran_id     = ran_id_ff;
   assign rsp_finished   = finished_ff;
   assign rsp_time_after = time_after_ff;
   assign rsp_all_done   = all_done_ff;

endmodule
`default_nettype wire
